### rtl/canopy_interception_cell_update_core_assert.svh
// ----------------------------------------------------------------------------
// canopy interception core assertion macros
// property wrappers used by the checker file of this block
// ----------------------------------------------------------------------------
`ifndef CANOPY_INTERCEPTION_CELL_UPDATE_CORE_ASSERT_SVH
`define CANOPY_INTERCEPTION_CELL_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define CIU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CIU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ciu_pkg.sv
// ----------------------------------------------------------------------------
// ciu_pkg
// shared widths, register codes and control structs of the interception core
// ----------------------------------------------------------------------------
package ciu_pkg;

    // field widths
    localparam int TimeStepW = 24;
    localparam int InvStepW  = 40;
    localparam int CellAreaW = 32;
    localparam int RateW     = 40;
    localparam int DepthW    = 40;
    localparam int LenW      = 24;
    localparam int IdxW      = 12;
    localparam int ClassW    = 2;
    localparam int VolW      = 64;

    // one store entry holds depth, intercepted volume and net volume
    localparam int StoreW = DepthW + 2 * VolW;

    // default number of grid cells
    localparam int CiuCells = 4096;

    // apb port
    localparam int ApbAddrW = 5;
    localparam int ApbDataW = 64;

    // register index codes, taken from paddr[4:3]
    localparam logic [1:0] CfgTimeStep = 2'd0;
    localparam logic [1:0] CfgInvStep  = 2'd1;
    localparam logic [1:0] CfgCellArea = 2'd2;

    localparam logic [TimeStepW-1:0] TimeStepRst = 24'd256;
    localparam logic [InvStepW-1:0]  InvStepRst  = 40'h01_0000_0000;
    localparam logic [CellAreaW-1:0] CellAreaRst = 32'd256;

    // shared multiply-accumulate unit: a is taken in digits, b whole
    localparam int DigitW    = 24;
    localparam int MulAW     = 72;
    localparam int MulBW     = 40;
    localparam int MacPartW  = DigitW + MulBW;
    localparam int MacProdW  = MulAW + MulBW;

    typedef struct packed {
        logic       start;
        logic [1:0] digits;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_sts;

endpackage

### rtl/canopy_interception_cell_update_core.sv
// ----------------------------------------------------------------------------
// canopy_interception_cell_update_core
// per-cell rainfall interception update with a shared multiplier sequencer
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) carries one request per grid cell:
//   func 0 loads a cell's interception capacity and clears its volumes, func 1
//   applies one rain step. output channel (o_out_valid / i_out_ready) returns
//   exactly one result per request, in request order.
//   the apb port holds time step, reciprocal time step and cell area; write it
//   only while no request is in flight.
// sequence
//   rain request: store read and fetch, then six products run one after another
//   through the single 24 x 40 multiplier, with a split after the third, then
//   store write and done. load request: store write, then done.
//   out-of-range index or rain on an outside-domain cell: straight to done.
//   a new request is taken only after the current one has finished.
// reset
//   clears the sequencer and the output valid; configuration returns to its
//   defaults. the cell store is not cleared: a cell must be loaded before rain.
// stall
//   a finished result sits in the output register; the core keeps taking new
//   requests and only waits at the end of one if that register is still full.
// ----------------------------------------------------------------------------
module canopy_interception_cell_update_core #(
    parameter int CELLS = ciu_pkg::CiuCells
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [ciu_pkg::IdxW-1:0]          i_cell_index,
    input  logic [ciu_pkg::ClassW-1:0]        i_cell_class,
    input  logic [ciu_pkg::RateW-1:0]         i_gross_rate,
    input  logic [ciu_pkg::LenW-1:0]          i_channel_length,
    input  logic [ciu_pkg::LenW-1:0]          i_channel_width,
    input  logic [ciu_pkg::DepthW-1:0]        i_initial_capacity,

    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_in_domain,
    output logic [ciu_pkg::RateW-1:0]         o_net_rate,
    output logic [ciu_pkg::DepthW-1:0]        o_remaining_capacity,
    output logic [ciu_pkg::VolW-1:0]          o_intercepted_total,
    output logic [ciu_pkg::VolW-1:0]          o_net_total,

    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ciu_pkg::ApbAddrW-1:0]      paddr,
    input  logic [ciu_pkg::ApbDataW-1:0]      pwdata,
    output logic [ciu_pkg::ApbDataW-1:0]      prdata,
    output logic                              pready
);

    localparam int AddrW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IdxW   = ciu_pkg::IdxW;
    localparam int VolW   = ciu_pkg::VolW;
    localparam int DepthW = ciu_pkg::DepthW;
    localparam int RateW  = ciu_pkg::RateW;
    localparam int MulAW  = ciu_pkg::MulAW;
    localparam int MulBW  = ciu_pkg::MulBW;
    localparam int DataW  = ciu_pkg::ApbDataW;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_ISSUE,
        S_WAIT,
        S_SPLIT,
        S_WRITE,
        S_DONE
    } t_state;

    // products taken through the shared multiplier, in this order
    typedef enum logic [2:0] {
        OP_DEPTH,   // gross rate * time step
        OP_CHAN,    // channel length * width
        OP_QUOT,    // capacity * reciprocal time step
        OP_TAKEN,   // intercepted depth * effective area
        OP_NETD,    // net rate * time step
        OP_NETV     // (net rate * time step) * cell area
    } t_op;

    function automatic logic [VolW-1:0] sat_add(input logic [VolW-1:0] a,
                                                input logic [VolW-1:0] b);
        logic [VolW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VolW] ? '1 : s[VolW-1:0];
    endfunction

    // configuration
    logic [ciu_pkg::TimeStepW-1:0] r_time_step;
    logic [ciu_pkg::InvStepW-1:0]  r_inv_step;
    logic [ciu_pkg::CellAreaW-1:0] r_cell_area;
    logic [1:0]                    w_cfg_sel;
    logic                          w_cfg_wr;

    // sequencer
    t_state r_state;
    t_state n_state;
    t_op    r_op;

    // working registers for one request
    logic [AddrW-1:0]              r_addr;
    logic                          r_chan_en;
    logic [RateW-1:0]              r_gross;
    logic [ciu_pkg::LenW-1:0]      r_len;
    logic [ciu_pkg::LenW-1:0]      r_wid;
    logic [55:0]                   r_depth;
    logic [39:0]                   r_chan;
    logic [47:0]                   r_q;
    logic [ciu_pkg::CellAreaW-1:0] r_area;
    logic [DepthW-1:0]             r_taken;
    logic [63:0]                   r_nd;
    logic                          r_indom;
    logic [RateW-1:0]              r_net;
    logic [DepthW-1:0]             r_cap;
    logic [VolW-1:0]               r_ivol;
    logic [VolW-1:0]               r_nvol;

    // output register
    logic                          r_out_valid;
    logic                          r_o_in_domain;
    logic [RateW-1:0]              r_o_net_rate;
    logic [DepthW-1:0]             r_o_cap;
    logic [VolW-1:0]               r_o_ivol;
    logic [VolW-1:0]               r_o_nvol;

    logic                          w_in_acc;
    logic                          w_in_range;
    logic                          w_rain_skip;
    logic [AddrW+IdxW-1:0]         w_idx_ext;
    logic                          w_out_free;
    logic                          w_out_load;

    // multiplier hookup
    ciu_pkg::t_mac_ctl             w_mac_ctl;
    ciu_pkg::t_mac_sts             w_mac_sts;
    logic [MulAW-1:0]              w_mac_a;
    logic [MulBW-1:0]              w_mac_b;
    logic [ciu_pkg::MacProdW-1:0]  w_prod;

    // store
    logic [ciu_pkg::StoreW-1:0]    w_rd_data;
    logic [ciu_pkg::StoreW-1:0]    w_wr_data;

    // ------------------------------------------------------------------------
    // apb registers, index from paddr[4:3], always ready
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_sel = paddr[4:3];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= ciu_pkg::TimeStepRst;
            r_inv_step  <= ciu_pkg::InvStepRst;
            r_cell_area <= ciu_pkg::CellAreaRst;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_sel)
                ciu_pkg::CfgTimeStep: r_time_step <= pwdata[ciu_pkg::TimeStepW-1:0];
                ciu_pkg::CfgInvStep:  r_inv_step  <= pwdata[ciu_pkg::InvStepW-1:0];
                ciu_pkg::CfgCellArea: r_cell_area <= pwdata[ciu_pkg::CellAreaW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_sel)
            ciu_pkg::CfgTimeStep: prdata = DataW'(r_time_step);
            ciu_pkg::CfgInvStep:  prdata = DataW'(r_inv_step);
            ciu_pkg::CfgCellArea: prdata = DataW'(r_cell_area);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_in_range  = (32'(i_cell_index) < 32'(CELLS));
    assign w_idx_ext   = (AddrW + IdxW)'(i_cell_index);
    // rain on a cell outside the domain touches nothing
    assign w_rain_skip = i_func && (i_cell_class == '0);

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = (r_state == S_DONE) && w_out_free;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_in_range || w_rain_skip) begin
                        n_state = S_DONE;
                    end else if (!i_func) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_FETCH;
            S_FETCH: n_state = S_ISSUE;
            S_ISSUE: begin
                if (!w_mac_sts.busy) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_mac_sts.done) begin
                    if (r_op == OP_QUOT) begin
                        n_state = S_SPLIT;
                    end else if (r_op == OP_NETV) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_SPLIT: n_state = S_ISSUE;
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // multiplier operand select
    // ------------------------------------------------------------------------
    always_comb begin
        w_mac_ctl.start = (r_state == S_ISSUE) && !w_mac_sts.busy;
        unique case (r_op)
            OP_DEPTH: begin
                w_mac_a          = MulAW'(r_time_step);
                w_mac_b          = MulBW'(r_gross);
                w_mac_ctl.digits = 2'd1;
            end
            OP_CHAN: begin
                w_mac_a          = MulAW'(r_len);
                w_mac_b          = MulBW'(r_wid);
                w_mac_ctl.digits = 2'd1;
            end
            OP_QUOT: begin
                w_mac_a          = MulAW'(r_cap);
                w_mac_b          = MulBW'(r_inv_step);
                w_mac_ctl.digits = 2'd2;
            end
            OP_TAKEN: begin
                w_mac_a          = MulAW'(r_area);
                w_mac_b          = MulBW'(r_taken);
                w_mac_ctl.digits = 2'd2;
            end
            OP_NETD: begin
                w_mac_a          = MulAW'(r_time_step);
                w_mac_b          = MulBW'(r_net);
                w_mac_ctl.digits = 2'd1;
            end
            OP_NETV: begin
                w_mac_a          = MulAW'(r_nd);
                w_mac_b          = MulBW'(r_cell_area);
                w_mac_ctl.digits = 2'd3;
            end
            default: begin
                w_mac_a          = '0;
                w_mac_b          = '0;
                w_mac_ctl.digits = 2'd1;
            end
        endcase
    end

    ciu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_sts   (w_mac_sts),
        .o_prod  (w_prod)
    );

    // ------------------------------------------------------------------------
    // cell store: {remaining depth, intercepted volume, net volume}
    // ------------------------------------------------------------------------
    assign w_wr_data = {r_cap, r_ivol, r_nvol};

    ciu_ram #(
        .DataW (ciu_pkg::StoreW),
        .Depth (CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_addr    <= w_idx_ext[AddrW-1:0];
                    r_chan_en <= i_cell_class[1];  // class two and three carry a channel
                    r_gross   <= i_gross_rate;
                    r_len     <= i_channel_length;
                    r_wid     <= i_channel_width;
                    r_indom   <= w_in_range && !w_rain_skip;
                    r_net     <= '0;
                    r_ivol    <= '0;
                    r_nvol    <= '0;
                    // a load writes its capacity and zero volumes straight to the store
                    if (w_in_range && !i_func) begin
                        r_cap <= i_initial_capacity;
                    end else begin
                        r_cap <= '0;
                    end
                end
            end
            S_FETCH: begin
                r_cap  <= w_rd_data[ciu_pkg::StoreW-1 -: DepthW];
                r_ivol <= w_rd_data[2*VolW-1 -: VolW];
                r_nvol <= w_rd_data[VolW-1:0];
                r_op   <= OP_DEPTH;
            end
            S_WAIT: begin
                if (w_mac_sts.done) begin
                    unique case (r_op)
                        OP_DEPTH: begin
                            r_depth <= w_prod[63:8];
                            r_op    <= OP_CHAN;
                        end
                        OP_CHAN: begin
                            r_chan <= r_chan_en ? w_prod[47:8] : '0;
                            r_op   <= OP_QUOT;
                        end
                        OP_QUOT: begin
                            r_q <= w_prod[79:32];
                            // area left for interception, clamped at zero
                            if ({8'd0, r_cell_area} > r_chan) begin
                                r_area <= r_cell_area - r_chan[31:0];
                            end else begin
                                r_area <= '0;
                            end
                        end
                        OP_TAKEN: begin
                            r_ivol <= sat_add(r_ivol, VolW'(w_prod[71:24]));
                            r_op   <= OP_NETD;
                        end
                        OP_NETD: begin
                            r_nd <= w_prod[63:0];
                            r_op <= OP_NETV;
                        end
                        OP_NETV: begin
                            r_nvol <= sat_add(r_nvol, w_prod[95:32]);
                        end
                        default: ;
                    endcase
                end
            end
            S_SPLIT: begin
                r_op <= OP_TAKEN;
                if (r_cap == '0) begin
                    // nothing left to hold: all rain passes
                    r_net   <= r_gross;
                    r_taken <= '0;
                end else if (r_depth >= 56'(r_cap)) begin
                    // capacity fills up, the rest passes at gross minus cap/dt
                    if (48'(r_gross) > r_q) begin
                        r_net <= r_gross - r_q[RateW-1:0];
                    end else begin
                        r_net <= '0;
                    end
                    r_taken <= r_cap;
                    r_cap   <= '0;
                end else begin
                    // whole step depth is held
                    r_net   <= '0;
                    r_taken <= r_depth[DepthW-1:0];
                    r_cap   <= r_cap - r_depth[DepthW-1:0];
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_in_domain <= r_indom;
            r_o_net_rate  <= r_net;
            r_o_cap       <= r_cap;
            r_o_ivol      <= r_ivol;
            r_o_nvol      <= r_nvol;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_in_domain          = r_o_in_domain;
    assign o_net_rate           = r_o_net_rate;
    assign o_remaining_capacity = r_o_cap;
    assign o_intercepted_total  = r_o_ivol;
    assign o_net_total          = r_o_nvol;

endmodule

### rtl/ciu_ram.sv
// ----------------------------------------------------------------------------
// ciu_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module ciu_ram #(
    parameter int DataW = ciu_pkg::StoreW,
    parameter int Depth = ciu_pkg::CiuCells,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [DataW-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [DataW-1:0] o_rd_data
);

    logic [DataW-1:0] r_mem [Depth];
    logic [DataW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ciu_mac.sv
// ----------------------------------------------------------------------------
// ciu_mac
// shared digit-serial multiplier, 24 x 40 bits per cycle into a wide accumulator
// ----------------------------------------------------------------------------
module ciu_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ciu_pkg::t_mac_ctl                 i_ctl,
    input  logic [ciu_pkg::MulAW-1:0]         i_a,
    input  logic [ciu_pkg::MulBW-1:0]         i_b,
    output ciu_pkg::t_mac_sts                 o_sts,
    output logic [ciu_pkg::MacProdW-1:0]      o_prod
);

    localparam int ProdW = ciu_pkg::MacProdW;
    localparam int PartW = ciu_pkg::MacPartW;
    localparam int DigW  = ciu_pkg::DigitW;

    logic [ciu_pkg::MulAW-1:0] r_a;
    logic [ciu_pkg::MulBW-1:0] r_b;
    logic [1:0]                r_left;
    logic [1:0]                r_k;
    logic                      r_busy;
    logic [PartW-1:0]          r_p;
    logic [1:0]                r_pk;
    logic                      r_pv;
    logic                      r_plast;
    logic [ProdW-1:0]          r_acc;
    logic                      r_done;
    logic [ProdW-1:0]          w_addend;

    // align the registered partial product to its digit
    always_comb begin
        case (r_pk)
            2'd0:    w_addend = ProdW'(r_p);
            2'd1:    w_addend = ProdW'(r_p) << DigW;
            2'd2:    w_addend = ProdW'(r_p) << (2 * DigW);
            default: w_addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= r_busy;
            r_done <= r_pv && r_plast;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_left == 2'd1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_left <= i_ctl.digits;
            r_k    <= 2'd0;
        end else if (r_busy) begin
            r_p     <= PartW'(r_a[DigW-1:0]) * PartW'(r_b);
            r_pk    <= r_k;
            r_plast <= (r_left == 2'd1);
            r_a     <= r_a >> DigW;
            r_k     <= r_k + 2'd1;
            r_left  <= r_left - 2'd1;
        end
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_sts.busy = r_busy | r_pv;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

### rtl/ciu_checker.sv
// ----------------------------------------------------------------------------
// ciu_checker
// port-level checks of the interception core, bound to the top level
// ----------------------------------------------------------------------------
`include "canopy_interception_cell_update_core_assert.svh"

module ciu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_in_domain,
    input logic [ciu_pkg::RateW-1:0]     i_net_rate,
    input logic [ciu_pkg::DepthW-1:0]    i_remaining_capacity,
    input logic [ciu_pkg::VolW-1:0]      i_intercepted_total,
    input logic [ciu_pkg::VolW-1:0]      i_net_total
);

    // a stalled result keeps its payload
    `CIU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_net_rate) && $stable(i_remaining_capacity)
            && $stable(i_intercepted_total) && $stable(i_net_total),
        "stalled result changed")

    // one request at a time: ready drops right after an accepted request
    `CIU_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n,
        i_in_valid && i_in_ready,
        !i_in_ready,
        "request accepted while busy")

    // a result outside the domain carries only zeros
    `CIU_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n,
        i_out_valid && !i_in_domain,
        (i_net_rate == '0) && (i_remaining_capacity == '0)
            && (i_intercepted_total == '0) && (i_net_total == '0),
        "outside-domain result not zero")

    // rain passes on only once the capacity is used up
    `CIU_ASSERT_NOW(a_net_needs_empty, i_clk, i_rst_n,
        i_out_valid && (i_net_rate != '0),
        i_remaining_capacity == '0,
        "net rain with capacity left")

endmodule

bind canopy_interception_cell_update_core ciu_checker u_ciu_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .i_in_ready           (o_in_ready),
    .i_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .i_in_domain          (o_in_domain),
    .i_net_rate           (o_net_rate),
    .i_remaining_capacity (o_remaining_capacity),
    .i_intercepted_total  (o_intercepted_total),
    .i_net_total          (o_net_total)
);

### test/canopy_interception_cell_update_core_test.sv
// ----------------------------------------------------------------------------
// canopy_interception_cell_update_core_test
// self-checking bench: a cycle-free model of the cell store predicts every
// result, random traffic with idle gaps and receiver stalls runs under several
// configurations written over apb, and each result is compared in order
// ----------------------------------------------------------------------------
module canopy_interception_cell_update_core_test;

    import ciu_pkg::*;

    // request function codes
    localparam logic FuncLoad = 1'b0;
    localparam logic FuncRain = 1'b1;

    // cell class codes
    localparam logic [1:0] ClassOutside     = 2'd0;
    localparam logic [1:0] ClassOverland    = 2'd1;
    localparam logic [1:0] ClassChannel     = 2'd2;
    localparam logic [1:0] ClassChannelWide = 2'd3;

    localparam int CycleLimit    = 1500000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 60;
    localparam int MaxPrinted    = 40;

    typedef struct packed {
        logic                 func;
        logic [IdxW-1:0]      idx;
        logic [ClassW-1:0]    cls;
        logic [RateW-1:0]     gross;
        logic [LenW-1:0]      len;
        logic [LenW-1:0]      wid;
        logic [DepthW-1:0]    init;
    } cell_req_t;

    typedef struct packed {
        logic                 in_domain;
        logic [RateW-1:0]     net_rate;
        logic [DepthW-1:0]    cap_left;
        logic [VolW-1:0]      icpt_total;
        logic [VolW-1:0]      net_total;
    } cell_res_t;

    // ------------------------------------------------------------------------
    // cell store model and in-order result checker
    // ------------------------------------------------------------------------
    class cell_update_tracker;
        logic [TimeStepW-1:0] step_len;
        logic [InvStepW-1:0]  step_recip;
        logic [CellAreaW-1:0] area_cfg;
        logic [DepthW-1:0]    depth_left [CiuCells];
        logic [VolW-1:0]      icpt_vol   [CiuCells];
        logic [VolW-1:0]      net_vol    [CiuCells];
        bit                   loaded     [CiuCells];
        cell_res_t            pending_updates[$];
        int                   fails;
        int                   results_seen;

        function new();
            step_len     = TimeStepRst;
            step_recip   = InvStepRst;
            area_cfg     = CellAreaRst;
            fails        = 0;
            results_seen = 0;
        endfunction

        function void set_cfg(logic [1:0] code, logic [63:0] value);
            case (code)
                CfgTimeStep: step_len   = value[TimeStepW-1:0];
                CfgInvStep:  step_recip = value[InvStepW-1:0];
                CfgCellArea: area_cfg   = value[CellAreaW-1:0];
                default: ;
            endcase
        endfunction

        function logic [VolW-1:0] sat_add(logic [VolW-1:0] acc, logic [127:0] inc);
            logic [127:0] sum;
            sum = 128'(acc) + inc;
            if (sum > 128'({VolW{1'b1}})) return {VolW{1'b1}};
            return sum[VolW-1:0];
        endfunction

        // one request against the store, returns the result it must produce
        function cell_res_t predict_update(cell_req_t r);
            cell_res_t        res;
            logic [127:0]     depth;
            logic [127:0]     chan;
            logic [127:0]     area;
            logic [127:0]     quot;
            logic [127:0]     taken;
            logic [DepthW-1:0] cap;
            logic [RateW-1:0] net_r;
            res = '0;
            if (int'(r.idx) >= CiuCells) return res;
            if (r.func == FuncLoad) begin
                depth_left[r.idx] = r.init;
                icpt_vol[r.idx]   = '0;
                net_vol[r.idx]    = '0;
                loaded[r.idx]     = 1'b1;
                res.in_domain     = 1'b1;
                res.cap_left      = r.init;
                return res;
            end
            // rain outside the domain leaves the cell alone
            if (r.cls == ClassOutside) return res;
            cap   = depth_left[r.idx];
            net_r = r.gross;
            if (cap != '0) begin
                // class three counts as a channel cell
                chan  = (r.cls >= ClassChannel) ? ((128'(r.len) * 128'(r.wid)) >> 8) : '0;
                area  = (128'(area_cfg) > chan) ? 128'(area_cfg) - chan : '0;
                depth = (128'(r.gross) * 128'(step_len)) >> 8;
                if (depth >= 128'(cap)) begin
                    // store runs dry, the excess passes through as net rain
                    quot  = (128'(cap) * 128'(step_recip)) >> 32;
                    net_r = (128'(r.gross) > quot) ? RateW'(128'(r.gross) - quot) : '0;
                    taken = 128'(cap);
                    cap   = '0;
                end else begin
                    net_r = '0;
                    taken = depth;
                    cap   = cap - DepthW'(depth);
                end
                icpt_vol[r.idx]   = sat_add(icpt_vol[r.idx], (taken * area) >> 24);
                depth_left[r.idx] = cap;
            end
            net_vol[r.idx] = sat_add(net_vol[r.idx],
                (128'(net_r) * 128'(area_cfg) * 128'(step_len)) >> 32);
            res.in_domain  = 1'b1;
            res.net_rate   = net_r;
            res.cap_left   = cap;
            res.icpt_total = icpt_vol[r.idx];
            res.net_total  = net_vol[r.idx];
            return res;
        endfunction

        task report(input string msg);
            fails++;
            if (fails <= MaxPrinted) $display("mismatch: %s", msg);
        endtask

        task take_request(input cell_req_t r);
            pending_updates.push_back(predict_update(r));
        endtask

        task match_result(input cell_res_t got);
            cell_res_t want;
            results_seen++;
            if (pending_updates.size() == 0) begin
                report($sformatf("result %0d arrived with no request waiting", results_seen));
            end else begin
                want = pending_updates.pop_front();
                if (got.in_domain !== want.in_domain)
                    report($sformatf("result %0d in_domain got %b want %b",
                        results_seen, got.in_domain, want.in_domain));
                if (got.net_rate !== want.net_rate)
                    report($sformatf("result %0d net_rate got %h want %h",
                        results_seen, got.net_rate, want.net_rate));
                if (got.cap_left !== want.cap_left)
                    report($sformatf("result %0d remaining_capacity got %h want %h",
                        results_seen, got.cap_left, want.cap_left));
                if (got.icpt_total !== want.icpt_total)
                    report($sformatf("result %0d intercepted_total got %h want %h",
                        results_seen, got.icpt_total, want.icpt_total));
                if (got.net_total !== want.net_total)
                    report($sformatf("result %0d net_total got %h want %h",
                        results_seen, got.net_total, want.net_total));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic                i_in_valid;
    logic                o_in_ready;
    cell_req_t           offer;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_in_domain;
    logic [RateW-1:0]    o_net_rate;
    logic [DepthW-1:0]   o_remaining_capacity;
    logic [VolW-1:0]     o_intercepted_total;
    logic [VolW-1:0]     o_net_total;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    canopy_interception_cell_update_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_func               (offer.func),
        .i_cell_index         (offer.idx),
        .i_cell_class         (offer.cls),
        .i_gross_rate         (offer.gross),
        .i_channel_length     (offer.len),
        .i_channel_width      (offer.wid),
        .i_initial_capacity   (offer.init),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_in_domain          (o_in_domain),
        .o_net_rate           (o_net_rate),
        .o_remaining_capacity (o_remaining_capacity),
        .o_intercepted_total  (o_intercepted_total),
        .o_net_total          (o_net_total),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    cell_update_tracker tracker;
    cell_res_t          got_res;
    int                 cycle_count = 0;
    int                 hold_off_asks = 0;
    int                 hold_off_done = 0;
    int                 burst_left = 0;
    logic [IdxW-1:0]    recent_cells[$];
    logic [IdxW-1:0]    loaded_list[$];

    assign got_res = {o_in_domain, o_net_rate, o_remaining_capacity,
                      o_intercepted_total, o_net_total};

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("[canopy_interception_cell_update_core] ERROR");
            $finish;
        end
    end

    // every accepted result goes to the checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            tracker.match_result(got_res);
    end

    // ------------------------------------------------------------------------
    // result side: ready runs and stalls, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int run_len;
        int stall_len;
        int pick;
        i_out_ready = 1'b0;
        forever begin
            if (hold_off_asks > hold_off_done) begin
                // long hold-off, counted here, so the core backs up into its input
                repeat (HoldOffCycles) begin
                    @(negedge i_clk);
                    i_out_ready = 1'b0;
                end
                hold_off_done++;
            end
            pick    = $urandom_range(0, 99);
            run_len = (pick < 10) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            repeat (run_len) begin
                @(negedge i_clk);
                i_out_ready = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)      stall_len = $urandom_range(1, 3);
            else if (pick < 95) stall_len = $urandom_range(4, 12);
            else                stall_len = $urandom_range(20, 80);
            repeat (stall_len) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // random value with a random bit length, so small and large magnitudes mix
    function automatic logic [63:0] rand_mag(int w);
        int          k;
        logic [63:0] v;
        k = $urandom_range(0, w);
        v = {$urandom, $urandom};
        if (k == 0) return '0;
        return v & ((64'd1 << k) - 64'd1);
    endfunction

    function automatic cell_req_t mk(logic func, logic [IdxW-1:0] idx, logic [1:0] cls,
                                     logic [RateW-1:0] gross, logic [LenW-1:0] len,
                                     logic [LenW-1:0] wid, logic [DepthW-1:0] init);
        cell_req_t r;
        r.func  = func;
        r.idx   = idx;
        r.cls   = cls;
        r.gross = gross;
        r.len   = len;
        r.wid   = wid;
        r.init  = init;
        return r;
    endfunction

    // mostly rain on recently loaded cells, some rates sized to drain the store in
    // a few steps; loads land anywhere in the grid
    function automatic cell_req_t next_request();
        cell_req_t        r;
        int               pick;
        logic [DepthW-1:0] cap;
        logic [127:0]     tgt;
        r.gross = RateW'(rand_mag(RateW));
        r.len   = ($urandom_range(0, 9) == 0) ? '1 : LenW'(rand_mag(LenW));
        r.wid   = ($urandom_range(0, 9) == 0) ? '1 : LenW'(rand_mag(LenW));
        r.init  = DepthW'(rand_mag(DepthW));
        r.cls   = 2'($urandom_range(0, 3));
        if (recent_cells.size() == 0 || $urandom_range(0, 99) < 25) begin
            r.func = FuncLoad;
            r.idx  = IdxW'($urandom_range(0, CiuCells - 1));
            pick   = $urandom_range(0, 9);
            if (pick == 0)      r.init = '0;
            else if (pick == 1) r.init = '1;
        end else begin
            r.func = FuncRain;
            if ($urandom_range(0, 99) < 85)
                r.idx = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            else
                r.idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            r.cls = ($urandom_range(0, 99) < 10) ? ClassOutside : 2'($urandom_range(1, 3));
            cap   = tracker.depth_left[r.idx];
            pick  = $urandom_range(0, 99);
            if (pick < 10) begin
                r.gross = '0;
            end else if (pick < 15) begin
                r.gross = '1;
            end else if (pick >= 55 && cap != '0 && tracker.step_len != '0) begin
                tgt = (128'(cap) << 8) /
                      (128'(tracker.step_len) * 128'($urandom_range(1, 5)));
                tgt = tgt + 128'($urandom_range(0, 3));
                r.gross = (tgt > 128'({RateW{1'b1}})) ? '1 : tgt[RateW-1:0];
            end
        end
        return r;
    endfunction

    task send_request(input cell_req_t r);
        @(negedge i_clk);
        offer      = r;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        if (r.func == FuncLoad) begin
            if (!tracker.loaded[r.idx]) loaded_list.push_back(r.idx);
            recent_cells.push_back(r.idx);
            if (recent_cells.size() > 8) void'(recent_cells.pop_front());
        end
        tracker.take_request(r);
    endtask

    // gap after a request: mostly none or short, now and then long,
    // with occasional bursts of back-to-back requests
    task pause_sender();
        int pick;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       begin burst_left = $urandom_range(20, 60); gap = 0; end
            else if (pick < 45) gap = 0;
            else if (pick < 85) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 15);
            else                gap = $urandom_range(30, 100);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task send_plan(input cell_req_t plan[$]);
        foreach (plan[k]) begin
            send_request(plan[k]);
            pause_sender();
        end
    endtask

    task run_random(input int n_items, input int hold_at);
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at) hold_off_asks++;
            send_request(next_request());
            pause_sender();
        end
    endtask

    // every request yields a result, so an empty queue means the core is idle
    task settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_updates.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // apb port
    // ------------------------------------------------------------------------
    task apb_access(input logic wr, input logic [1:0] code, input logic [63:0] wdata,
                    output logic [63:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {code, 3'b000};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        if (wr) tracker.set_cfg(code, wdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task check_regs();
        logic [63:0] got;
        logic [63:0] want;
        logic [63:0] mask;
        logic [1:0]  code;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0:       code = CfgTimeStep;
                1:       code = CfgInvStep;
                default: code = CfgCellArea;
            endcase
            apb_access(1'b0, code, '0, got);
            case (code)
                CfgTimeStep: begin
                    want = 64'(tracker.step_len);
                    mask = 64'(TimeStepRst | {TimeStepW{1'b1}});
                end
                CfgInvStep: begin
                    want = 64'(tracker.step_recip);
                    mask = 64'({InvStepW{1'b1}});
                end
                default: begin
                    want = 64'(tracker.area_cfg);
                    mask = 64'({CellAreaW{1'b1}});
                end
            endcase
            if ((got & mask) !== want)
                tracker.report($sformatf("register %0d read %h want %h", code, got, want));
        end
    endtask

    task apply_setting(input logic [TimeStepW-1:0] ts, input logic [InvStepW-1:0] inv,
                       input logic [CellAreaW-1:0] area);
        logic [63:0] unused;
        apb_access(1'b1, CfgTimeStep, 64'(ts), unused);
        apb_access(1'b1, CfgInvStep, 64'(inv), unused);
        apb_access(1'b1, CfgCellArea, 64'(area), unused);
        check_regs();
    endtask

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        cell_req_t plan[$];
        tracker    = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        offer      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the registers
        check_regs();

        // directed requests under the reset configuration
        plan.push_back(mk(FuncLoad, 12'd0, ClassChannelWide, '0, '0, '0, '1));
        // load ignores the class, and capacity zero is legal
        plan.push_back(mk(FuncLoad, 12'd4095, ClassOutside, '1, '1, '1, '0));
        // empty store: all rain passes through
        plan.push_back(mk(FuncRain, 12'd4095, ClassOverland, '1, '0, '0, '0));
        // outside domain gives an all-zero result
        plan.push_back(mk(FuncRain, 12'd0, ClassOutside, '1, '1, '1, '1));
        plan.push_back(mk(FuncLoad, 12'd1, ClassOverland, '0, '0, '0, 40'd1000));
        // partial interception, then depth exactly equal to what is left
        plan.push_back(mk(FuncRain, 12'd1, ClassOverland, 40'd300, '0, '0, '0));
        plan.push_back(mk(FuncRain, 12'd1, ClassChannel, 40'd700, 24'd512, 24'd256, '0));
        plan.push_back(mk(FuncRain, 12'd1, ClassChannelWide, 40'd5, 24'd3, 24'd9, '0));
        // channel wider than the cell clamps the area to zero
        plan.push_back(mk(FuncLoad, 12'd2, ClassChannel, '0, '0, '0, 40'd100));
        plan.push_back(mk(FuncRain, 12'd2, ClassChannel, 40'd5000, '1, '1, '0));
        plan.push_back(mk(FuncLoad, 12'd3, ClassOverland, '0, '0, '0, '1));
        plan.push_back(mk(FuncRain, 12'd3, ClassOverland, '1, '0, '0, '0));
        plan.push_back(mk(FuncRain, 12'd0, ClassChannelWide, '0, 24'd1, 24'd1, '0));
        plan.push_back(mk(FuncRain, 12'd0, ClassOverland, '1, '1, '0, '0));
        // alternating bit patterns on every field
        plan.push_back(mk(FuncLoad, 12'hAAA, ClassChannel, '0, '0, '0, 40'hAA_AAAA_AAAA));
        plan.push_back(mk(FuncLoad, 12'h555, ClassOverland, '0, '0, '0, 40'h55_5555_5555));
        plan.push_back(mk(FuncRain, 12'hAAA, ClassChannel, 40'h55_5555_5555,
                          24'hAA_AAAA, 24'h55_5555, '0));
        plan.push_back(mk(FuncRain, 12'h555, ClassChannelWide, 40'hAA_AAAA_AAAA,
                          24'h55_5555, 24'hAA_AAAA, '0));
        send_plan(plan);
        run_random(200, -1);
        settle();

        // two-second step, with a long receiver hold-off
        apply_setting(24'd512, 40'h00_8000_0000, 32'd25600);
        run_random(220, 40);
        settle();

        // every register at its maximum, then drive the net volume into saturation
        apply_setting('1, '1, '1);
        plan.delete();
        plan.push_back(mk(FuncLoad, 12'd5, ClassOverland, '0, '0, '0, '1));
        plan.push_back(mk(FuncRain, 12'd5, ClassOverland, '1, '0, '0, '0));
        plan.push_back(mk(FuncRain, 12'd5, ClassOverland, '1, '0, '0, '0));
        plan.push_back(mk(FuncRain, 12'd5, ClassChannel, '1, '1, '1, '0));
        send_plan(plan);
        run_random(200, -1);
        settle();

        // every register at zero
        apply_setting('0, '0, '0);
        run_random(200, -1);
        settle();

        // shortest nonzero step
        apply_setting(24'd1, '1, CellAreaW'(rand_mag(CellAreaW)));
        run_random(200, -1);
        settle();

        // random configuration, second hold-off
        apply_setting(TimeStepW'(rand_mag(TimeStepW)), InvStepW'(rand_mag(InvStepW)),
                      CellAreaW'(rand_mag(CellAreaW)));
        run_random(260, 60);
        settle();

        // let any stray result show up before the verdict
        repeat (DrainCycles) @(posedge i_clk);
        if (tracker.fails == 0 && tracker.pending_updates.size() == 0) begin
            $display("[canopy_interception_cell_update_core] OK");
        end else begin
            $display("[canopy_interception_cell_update_core] ERROR");
        end
        $finish;
    end

endmodule
